// ----- src/avt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package avt_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned CW        = 32;
	localparam int unsigned RW        = 64;
	localparam int unsigned PW        = 2 * CW;
	localparam int unsigned SW        = PW + 2;
	localparam int unsigned TW        = SW + 1;
	localparam int unsigned IDXW      = 3;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [RW-1:0]        row_word_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec3_t;

	typedef struct packed {
		logic  first;
		vec3_t pos;
	} vertex_t;

	typedef struct packed {
		logic upd;
		logic restart;
	} box_ctl_t;

	typedef enum logic [IDXW-1:0] {
		REG_ENABLE     = 3'd0,
		REG_ROW_X_LIN  = 3'd1,
		REG_ROW_X_REST = 3'd2,
		REG_ROW_Y_LIN  = 3'd3,
		REG_ROW_Y_REST = 3'd4,
		REG_ROW_Z_LIN  = 3'd5,
		REG_ROW_Z_REST = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	localparam row_word_t ONE_LO = row_word_t'(64'd1 << FRAC_BITS);
	localparam row_word_t ONE_HI = row_word_t'(64'd1 << (FRAC_BITS + CW));

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

endpackage

`default_nettype wire

// ----- src/avt_vertex_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface avt_vertex_if;
	logic               valid;
	logic               ready;
	logic               first_vertex;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic signed [31:0] vertex_z;

	modport source (
		output valid, first_vertex, vertex_x, vertex_y, vertex_z,
		input  ready
	);

	modport sink (
		input  valid, first_vertex, vertex_x, vertex_y, vertex_z,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/avt_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface avt_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] box_min_x;
	logic signed [31:0] box_min_y;
	logic signed [31:0] box_min_z;
	logic signed [31:0] box_max_x;
	logic signed [31:0] box_max_y;
	logic signed [31:0] box_max_z;

	modport source (
		output valid, out_x, out_y, out_z,
		output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_z,
		input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/avt_row.sv -----
`timescale 1ns / 1ps
`default_nettype none

module avt_row (
	input  wire logic              clk,
	input  wire logic              ld,
	input  wire avt_pkg::vec3_t    pos,
	input  wire avt_pkg::row_word_t lin,
	input  wire avt_pkg::row_word_t rest,
	output avt_pkg::coord_t        res
);
	import avt_pkg::*;

	logic signed [PW-1:0] p0_s2;
	logic signed [PW-1:0] p1_s2;
	logic signed [PW-1:0] p2_s2;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] shifted;
	logic signed [TW-1:0] total;
	coord_t               off;

	always_ff @(posedge clk) begin
		if (ld) begin
			p0_s2 <= $signed(lin[CW-1:0])     * $signed(pos.x);
			p1_s2 <= $signed(lin[RW-1:CW])    * $signed(pos.y);
			p2_s2 <= $signed(rest[CW-1:0])    * $signed(pos.z);
		end
	end

	always_comb begin
		off     = $signed(rest[RW-1:CW]);
		sum     = SW'(p0_s2) + SW'(p1_s2) + SW'(p2_s2);
		shifted = sum >>> FRAC_BITS;
		total   = TW'(shifted) + TW'(off);
		if (total > TW'(COORD_MAX)) begin
			res = COORD_MAX;
		end else if (total < TW'(COORD_MIN)) begin
			res = COORD_MIN;
		end else begin
			res = total[CW-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- src/avt_bbox.sv -----
`timescale 1ns / 1ps
`default_nettype none

module avt_bbox (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire avt_pkg::box_ctl_t ctl,
	input  wire avt_pkg::vec3_t    pt,
	output avt_pkg::vec3_t         lo,
	output avt_pkg::vec3_t         hi
);
	import avt_pkg::*;

	vec3_t lo_q;
	vec3_t hi_q;
	vec3_t lo_d;
	vec3_t hi_d;

	always_comb begin
		lo_d.x = (ctl.restart || $signed(pt.x) < $signed(lo_q.x)) ? pt.x : lo_q.x;
		lo_d.y = (ctl.restart || $signed(pt.y) < $signed(lo_q.y)) ? pt.y : lo_q.y;
		lo_d.z = (ctl.restart || $signed(pt.z) < $signed(lo_q.z)) ? pt.z : lo_q.z;
		hi_d.x = (ctl.restart || $signed(pt.x) > $signed(hi_q.x)) ? pt.x : hi_q.x;
		hi_d.y = (ctl.restart || $signed(pt.y) > $signed(hi_q.y)) ? pt.y : hi_q.y;
		hi_d.z = (ctl.restart || $signed(pt.z) > $signed(hi_q.z)) ? pt.z : hi_q.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX};
			hi_q <= '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN};
		end else if (ctl.upd) begin
			lo_q <= lo_d;
			hi_q <= hi_d;
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;

endmodule

`default_nettype wire

// ----- src/affine_vertex_transform_bbox_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Affine vertex transform with running bounding box, signed Q16.16 throughout.
// Three register stages: input word, the nine 32x32 products, then the result
// word; a vertex moves through them in that order. One vertex is taken every
// cycle as long as the result side keeps up; each stage holds on its own, so a
// waiting result does not stop earlier stages from filling. Each coordinate is
// the sum of its row's products shifted down with floor rounding, plus the row
// offset, saturated to 32 bits. With the enable register clear, vertices pass
// straight through and the box holds. While it is set, the box fields show the
// box after the vertex in the same word.
// Write registers only while the unit is empty.
module affine_vertex_transform_bbox_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [63:0]           cfg_data,
	avt_vertex_if.sink                 vtx,
	avt_result_if.source               res
);
	import avt_pkg::*;

	logic      en_q;
	row_word_t rows_q [6];

	logic    v1_s1;
	logic    v2_s2;
	logic    v3_s3;
	vertex_t vertex_s1;
	vertex_t vertex_s2;
	vec3_t   out_s3;

	logic     rdy1;
	logic     rdy2;
	logic     rdy3;
	logic     ld2;
	logic     ld3;
	vec3_t    xf;
	vec3_t    sel;
	vec3_t    box_lo;
	vec3_t    box_hi;
	box_ctl_t box_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			rows_q[0] <= ONE_LO;
			rows_q[1] <= '0;
			rows_q[2] <= ONE_HI;
			rows_q[3] <= '0;
			rows_q[4] <= '0;
			rows_q[5] <= ONE_LO;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:     en_q      <= cfg_data[0];
				REG_ROW_X_LIN:  rows_q[0] <= cfg_data;
				REG_ROW_X_REST: rows_q[1] <= cfg_data;
				REG_ROW_Y_LIN:  rows_q[2] <= cfg_data;
				REG_ROW_Y_REST: rows_q[3] <= cfg_data;
				REG_ROW_Z_LIN:  rows_q[4] <= cfg_data;
				REG_ROW_Z_REST: rows_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy3      = !v3_s3 || res.ready;
	assign rdy2      = !v2_s2 || rdy3;
	assign rdy1      = !v1_s1 || rdy2;
	assign vtx.ready = rdy1;
	assign ld2       = rdy2 && v1_s1;
	assign ld3       = rdy3 && v2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= vtx.valid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && vtx.valid) begin
			vertex_s1.first <= vtx.first_vertex;
			vertex_s1.pos.x <= vtx.vertex_x;
			vertex_s1.pos.y <= vtx.vertex_y;
			vertex_s1.pos.z <= vtx.vertex_z;
		end
		if (ld2) begin
			vertex_s2 <= vertex_s1;
		end
		if (ld3) begin
			out_s3 <= sel;
		end
	end

	avt_row u_row_x (
		.clk  (clk),
		.ld   (ld2),
		.pos  (vertex_s1.pos),
		.lin  (rows_q[0]),
		.rest (rows_q[1]),
		.res  (xf.x)
	);

	avt_row u_row_y (
		.clk  (clk),
		.ld   (ld2),
		.pos  (vertex_s1.pos),
		.lin  (rows_q[2]),
		.rest (rows_q[3]),
		.res  (xf.y)
	);

	avt_row u_row_z (
		.clk  (clk),
		.ld   (ld2),
		.pos  (vertex_s1.pos),
		.lin  (rows_q[4]),
		.rest (rows_q[5]),
		.res  (xf.z)
	);

	assign sel             = en_q ? xf : vertex_s2.pos;
	assign box_ctl.upd     = ld3 && en_q;
	assign box_ctl.restart = vertex_s2.first;

	avt_bbox u_bbox (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (box_ctl),
		.pt     (xf),
		.lo     (box_lo),
		.hi     (box_hi)
	);

	assign res.valid     = v3_s3;
	assign res.out_x     = out_s3.x;
	assign res.out_y     = out_s3.y;
	assign res.out_z     = out_s3.z;
	assign res.box_min_x = box_lo.x;
	assign res.box_min_y = box_lo.y;
	assign res.box_min_z = box_lo.z;
	assign res.box_max_x = box_hi.x;
	assign res.box_max_y = box_hi.y;
	assign res.box_max_z = box_hi.z;

endmodule

`default_nettype wire
